// ===== sv/blpg_pkg.sv =====
// ----------------------------------------------------------------------------
// blpg_pkg
// Shared types and constants of the line pixel generator: command codes,
// payload widths and the queue status bundle.
// ----------------------------------------------------------------------------
package blpg_pkg;

  localparam int COLOR_BITS = 16;
  localparam int ADDR_BITS  = 32;

  // Command codes carried in the func field
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

endpackage

// ===== sv/blpg_fifo.sv =====
// ----------------------------------------------------------------------------
// blpg_fifo
// Small register queue with first-word fall-through read. Writes while full
// and reads while empty are ignored.
// ----------------------------------------------------------------------------
module blpg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [WIDTH-1:0]      wr_data,
  input  logic                  rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output blpg_pkg::fifo_status_t stat
);
  import blpg_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             wr_ok;
  logic             rd_ok;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == (AW+1)'(DEPTH));
  assign wr_ok      = wr_en && !stat.full;
  assign rd_ok      = rd_en && !stat.empty;
  assign rd_data    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (rd_ok) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({wr_ok, rd_ok})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/blpg_front.sv =====
// ----------------------------------------------------------------------------
// blpg_front
// Input side: accepts items and classifies them. For a load it works out
// the absolute deltas, step directions, axis swap and initial error term,
// and packs everything into one command word for the command queue.
// ----------------------------------------------------------------------------
module blpg_front #(
  parameter int X_BITS = 9,
  parameter int Y_BITS = 8,
  parameter int CMD_W  = 69
) (
  input  logic                              push,
  input  logic                              func,
  input  logic [X_BITS-1:0]                 x_start,
  input  logic [Y_BITS-1:0]                 y_start,
  input  logic [X_BITS-1:0]                 x_end,
  input  logic [Y_BITS-1:0]                 y_end,
  input  logic [blpg_pkg::COLOR_BITS-1:0]   line_color,
  input  blpg_pkg::fifo_status_t            cmd_stat,
  output logic                              cmd_wr,
  output logic [CMD_W-1:0]                  cmd_data
);
  import blpg_pkg::*;

  localparam int D_BITS = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
  localparam int E_BITS = D_BITS + 3;

  logic [X_BITS-1:0] dx;
  logic [Y_BITS-1:0] dy;
  logic              x_en, x_neg, y_en, y_neg;
  logic [D_BITS-1:0] dx_w, dy_w, major, minor;
  logic              swap;
  logic [E_BITS-1:0] err_init;
  logic              is_load;

  always_comb begin
    x_neg    = (x_end < x_start);
    x_en     = (x_end != x_start);
    dx       = x_neg ? (x_start - x_end) : (x_end - x_start);
    y_neg    = (y_end < y_start);
    y_en     = (y_end != y_start);
    dy       = y_neg ? (y_start - y_end) : (y_end - y_start);
    dx_w     = D_BITS'(dx);
    dy_w     = D_BITS'(dy);
    // steep line: y becomes the major axis
    swap     = (dy_w > dx_w);
    major    = swap ? dy_w : dx_w;
    minor    = swap ? dx_w : dy_w;
    err_init = E_BITS'({minor, 1'b0}) - E_BITS'(major);
    is_load  = (func == FUNC_LOAD);
  end

  assign cmd_wr   = push && !cmd_stat.full;
  assign cmd_data = {is_load, x_start, y_start, major, minor,
                     x_en, x_neg, y_en, y_neg, swap, err_init, line_color};

endmodule

// ===== sv/blpg_back.sv =====
// ----------------------------------------------------------------------------
// blpg_back
// Line stepper: takes one command a cycle from the command queue while the
// result queue has room, holds the active line, writes one pixel per step
// into it; the error update adds one of two terms set at load time.
// ----------------------------------------------------------------------------
module blpg_back #(
  parameter int X_BITS    = 9,
  parameter int Y_BITS    = 8,
  parameter int ROW_SHIFT = 10,
  parameter int CMD_W     = 69,
  parameter int OUT_W     = 53
) (
  input  logic                   clk,
  input  logic                   rst,
  input  blpg_pkg::fifo_status_t cmd_stat,
  input  logic [CMD_W-1:0]       cmd_data,
  output logic                   cmd_rd,
  input  blpg_pkg::fifo_status_t out_stat,
  output logic                   out_wr,
  output logic [OUT_W-1:0]       out_data
);
  import blpg_pkg::*;

  localparam int D_BITS   = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
  localparam int E_BITS   = D_BITS + 3;
  localparam int L_BITS   = D_BITS + 1;
  localparam int OFF_BITS = Y_BITS + ROW_SHIFT + 1;

  // unpacked command
  logic                  c_load;
  logic [X_BITS-1:0]     c_x;
  logic [Y_BITS-1:0]     c_y;
  logic [D_BITS-1:0]     c_major, c_minor;
  logic                  c_x_en, c_x_neg, c_y_en, c_y_neg, c_swap;
  logic [E_BITS-1:0]     c_err;
  logic [COLOR_BITS-1:0] c_color;

  assign {c_load, c_x, c_y, c_major, c_minor,
          c_x_en, c_x_neg, c_y_en, c_y_neg, c_swap, c_err, c_color} = cmd_data;

  // line state
  logic                  active;
  logic [X_BITS-1:0]     cur_x;
  logic [Y_BITS-1:0]     cur_y;
  logic                  x_en, x_neg, y_en, y_neg, swap;
  logic [E_BITS-1:0]     err, err_inc, err_dec;
  logic [L_BITS-1:0]     left;
  logic [COLOR_BITS-1:0] color;

  logic                  last;
  logic                  err_ge;
  logic                  x_mv, y_mv;
  logic [X_BITS-1:0]     cur_x_next;
  logic [Y_BITS-1:0]     cur_y_next;
  logic [E_BITS-1:0]     err_next;
  logic [OFF_BITS-1:0]   offset;

  always_comb begin
    cmd_rd  = !cmd_stat.empty && !out_stat.full;
    // a step with no line active is consumed and dropped
    out_wr  = cmd_rd && !c_load && active;
    last    = (left <= L_BITS'(1));
    err_ge  = !err[E_BITS-1];
    x_mv    = swap ? err_ge : 1'b1;
    y_mv    = swap ? 1'b1 : err_ge;
    cur_x_next = cur_x;
    if (x_mv && x_en) begin
      cur_x_next = x_neg ? (cur_x - X_BITS'(1)) : (cur_x + X_BITS'(1));
    end
    cur_y_next = cur_y;
    if (y_mv && y_en) begin
      cur_y_next = y_neg ? (cur_y - Y_BITS'(1)) : (cur_y + Y_BITS'(1));
    end
    err_next = err + (err_ge ? err_dec : err_inc);
    offset   = OFF_BITS'({cur_y, {ROW_SHIFT{1'b0}}}) + OFF_BITS'({cur_x, 1'b0});
    out_data = {cur_x, cur_y, offset, color, last};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd_rd) begin
      if (c_load) begin
        active <= 1'b1;
      end else if (active && last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_rd) begin
      if (c_load) begin
        cur_x   <= c_x;
        cur_y   <= c_y;
        x_en    <= c_x_en;
        x_neg   <= c_x_neg;
        y_en    <= c_y_en;
        y_neg   <= c_y_neg;
        swap    <= c_swap;
        err     <= c_err;
        err_inc <= E_BITS'({c_minor, 1'b0});
        err_dec <= E_BITS'({c_minor, 1'b0}) - E_BITS'({c_major, 1'b0});
        left    <= L_BITS'(c_major) + L_BITS'(1);
        color   <= c_color;
      end else if (active && !last) begin
        // advance; on the final pixel hold the position
        cur_x <= cur_x_next;
        cur_y <= cur_y_next;
        err   <= err_next;
        left  <= left - L_BITS'(1);
      end
    end
  end

endmodule

// ===== sv/bresenham_line_pixel_generator_core.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator_core
// Bresenham line engine: load a line, then step out one pixel per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive the fields and push while full is low. func = 0 loads
//   a line (endpoints and color), func = 1 steps out the next pixel. A load,
//   and a step with no line active, give no result.
//   Result queue: while empty is low the oldest pixel sits on pixel_*; pop
//   takes it. last_pixel marks the second endpoint; the line then goes idle.
//   Configuration: one register, frame_base, written by cfg_valid/cfg_data
//   while the block is idle, a rule for the user that the block does not
//   enforce; cfg_ready is always high. Timing: a step passes through the
//   command queue and the stepper into the result queue. One item per cycle
//   is sustained while the result queue has room; the stepper then takes a
//   command each cycle, its error update a single narrow add. A two-entry
//   command queue sits between input decode and the stepper, and a two-entry
//   result queue after it, so when pop is held low the block keeps taking
//   items until both queues fill, then raises full. Reset (rst, synchronous)
//   empties both queues, clears frame_base and leaves no line active.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator_core #(
  parameter int ROW_SHIFT = 10,
  parameter int X_BITS    = 9,
  parameter int Y_BITS    = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic                              func,
  input  logic [X_BITS-1:0]                 x_start,
  input  logic [Y_BITS-1:0]                 y_start,
  input  logic [X_BITS-1:0]                 x_end,
  input  logic [Y_BITS-1:0]                 y_end,
  input  logic [blpg_pkg::COLOR_BITS-1:0]   line_color,
  output logic                              empty,
  input  logic                              pop,
  output logic [X_BITS-1:0]                 pixel_x,
  output logic [Y_BITS-1:0]                 pixel_y,
  output logic [blpg_pkg::ADDR_BITS-1:0]    pixel_address,
  output logic [blpg_pkg::COLOR_BITS-1:0]   pixel_rgb,
  output logic                              last_pixel,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [blpg_pkg::ADDR_BITS-1:0]    cfg_data
);
  import blpg_pkg::*;

  localparam int D_BITS    = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
  localparam int E_BITS    = D_BITS + 3;
  localparam int OFF_BITS  = Y_BITS + ROW_SHIFT + 1;
  localparam int CMD_W     = 1 + X_BITS + Y_BITS + 2 * D_BITS + 5 + E_BITS + COLOR_BITS;
  localparam int OUT_W     = X_BITS + Y_BITS + OFF_BITS + COLOR_BITS + 1;
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  fifo_status_t         cmd_stat, out_stat;
  logic                 cmd_wr, cmd_rd, out_wr;
  logic [CMD_W-1:0]     cmd_wdata, cmd_rdata;
  logic [OUT_W-1:0]     out_wdata, out_rdata;
  logic [OFF_BITS-1:0]  head_offset;
  logic [ADDR_BITS-1:0] frame_base;

  blpg_front #(
    .X_BITS (X_BITS),
    .Y_BITS (Y_BITS),
    .CMD_W  (CMD_W)
  ) u_front (
    .push       (push),
    .func       (func),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .line_color (line_color),
    .cmd_stat   (cmd_stat),
    .cmd_wr     (cmd_wr),
    .cmd_data   (cmd_wdata)
  );

  blpg_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr),
    .wr_data (cmd_wdata),
    .rd_en   (cmd_rd),
    .rd_data (cmd_rdata),
    .stat    (cmd_stat)
  );

  blpg_back #(
    .X_BITS    (X_BITS),
    .Y_BITS    (Y_BITS),
    .ROW_SHIFT (ROW_SHIFT),
    .CMD_W     (CMD_W),
    .OUT_W     (OUT_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_stat (cmd_stat),
    .cmd_data (cmd_rdata),
    .cmd_rd   (cmd_rd),
    .out_stat (out_stat),
    .out_wr   (out_wr),
    .out_data (out_wdata)
  );

  blpg_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_wr),
    .wr_data (out_wdata),
    .rd_en   (pop),
    .rd_data (out_rdata),
    .stat    (out_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      frame_base <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign full      = cmd_stat.full;
  assign empty     = out_stat.empty;

  assign {pixel_x, pixel_y, head_offset, pixel_rgb, last_pixel} = out_rdata;
  assign pixel_address = frame_base + ADDR_BITS'(head_offset);

`ifndef SYNTHESIS
  a_cmd_q_sane: assert property (@(posedge clk) disable iff (rst)
    !(cmd_stat.full && cmd_stat.empty))
    else $error("command queue reports full and empty together");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    out_stat.full |-> !out_wr)
    else $error("stepper wrote a pixel into a full result queue");

  a_pixel_from_cmd: assert property (@(posedge clk) disable iff (rst)
    out_wr |-> (cmd_rd && !cmd_stat.empty))
    else $error("pixel produced without consuming a command");

  a_result_after_write: assert property (@(posedge clk) disable iff (rst)
    (out_wr && out_stat.empty) |=> !empty)
    else $error("pixel written to empty result queue did not show");
`endif

endmodule

// ===== bench/bresenham_line_pixel_generator_checker.sv =====
// ----------------------------------------------------------------------------
// Line pixel generator checker
// Watches the item, result and frame base channels of the line engine,
// traces each line in step with the block and compares every popped pixel
// with the oldest predicted one. Mismatches are counted for the top level.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator_checker #(
  parameter int ROW_SHIFT = 10,
  parameter int X_BITS    = 9,
  parameter int Y_BITS    = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  logic                            func,
  input  logic [X_BITS-1:0]               x_start,
  input  logic [Y_BITS-1:0]               y_start,
  input  logic [X_BITS-1:0]               x_end,
  input  logic [Y_BITS-1:0]               y_end,
  input  logic [blpg_pkg::COLOR_BITS-1:0] line_color,
  input  logic                            empty,
  input  logic                            pop,
  input  logic [X_BITS-1:0]               pixel_x,
  input  logic [Y_BITS-1:0]               pixel_y,
  input  logic [blpg_pkg::ADDR_BITS-1:0]  pixel_address,
  input  logic [blpg_pkg::COLOR_BITS-1:0] pixel_rgb,
  input  logic                            last_pixel,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [blpg_pkg::ADDR_BITS-1:0]  cfg_data,
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [X_BITS-1:0]               x;
    logic [Y_BITS-1:0]               y;
    logic [blpg_pkg::ADDR_BITS-1:0]  addr;
    logic [blpg_pkg::COLOR_BITS-1:0] color;
    logic                            last;
  } pixel_t;

  pixel_t expected_pixels[$];

  logic [blpg_pkg::ADDR_BITS-1:0]  frame_base;
  logic [X_BITS-1:0]               pos_x;
  logic [Y_BITS-1:0]               pos_y;
  logic [blpg_pkg::COLOR_BITS-1:0] line_rgb;
  int                              major_len;
  int                              minor_len;
  int                              dir_x;
  int                              dir_y;
  int                              decision;
  int                              pixels_to_go;
  bit                              steep;
  bit                              drawing;

  // Advance the line tracer by one accepted item and queue any pixel it emits.
  task trace_line;
    int     dx;
    int     dy;
    pixel_t px;
    if (func == blpg_pkg::FUNC_LOAD) begin
      dx    = int'(x_end) - int'(x_start);
      dy    = int'(y_end) - int'(y_start);
      dir_x = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
      dir_y = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      steep = dy > dx;
      major_len    = steep ? dy : dx;
      minor_len    = steep ? dx : dy;
      decision     = 2 * minor_len - major_len;
      pixels_to_go = major_len + 1;
      pos_x    = x_start;
      pos_y    = y_start;
      line_rgb = line_color;
      drawing  = 1'b1;
    end else if (drawing) begin
      px.x     = pos_x;
      px.y     = pos_y;
      px.addr  = frame_base + (32'(pos_y) << ROW_SHIFT) + (32'(pos_x) << 1);
      px.color = line_rgb;
      px.last  = pixels_to_go <= 1;
      expected_pixels.push_back(px);
      if (px.last) begin
        // hold position, go idle
        pixels_to_go = 0;
        drawing      = 1'b0;
      end else begin
        pixels_to_go--;
        if (decision >= 0) begin
          if (steep) pos_x = pos_x + X_BITS'(dir_x);
          else pos_y = pos_y + Y_BITS'(dir_y);
          decision -= 2 * major_len;
        end
        if (steep) pos_y = pos_y + Y_BITS'(dir_y);
        else pos_x = pos_x + X_BITS'(dir_x);
        decision += 2 * minor_len;
      end
    end
  endtask

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst) begin
      expected_pixels.delete();
      errors       = 0;
      frame_base   = '0;
      pos_x        = '0;
      pos_y        = '0;
      line_rgb     = '0;
      major_len    = 0;
      minor_len    = 0;
      dir_x        = 0;
      dir_y        = 0;
      decision     = 0;
      pixels_to_go = 0;
      steep        = 1'b0;
      drawing      = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) frame_base = cfg_data;
      if (pop && !empty) begin
        got = '{pixel_x, pixel_y, pixel_address, pixel_rgb, last_pixel};
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel transfer: expected none", $time);
          $display("%0t:   actual x=%0d y=%0d addr=%h color=%h last=%b",
                   $time, got.x, got.y, got.addr, got.color, got.last);
        end else begin
          want = expected_pixels.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.addr !== want.addr ||
              got.color !== want.color || got.last !== want.last) begin
            errors++;
            $display("%0t: pixel mismatch: expected x=%0d y=%0d addr=%h color=%h last=%b",
                     $time, want.x, want.y, want.addr, want.color, want.last);
            $display("%0t:                 actual   x=%0d y=%0d addr=%h color=%h last=%b",
                     $time, got.x, got.y, got.addr, got.color, got.last);
          end
        end
      end
      if (push && !full) trace_line();
    end
    pending = expected_pixels.size();
  end

endmodule

// ===== bench/bresenham_line_pixel_generator_core_tb.sv =====
// ----------------------------------------------------------------------------
// Line pixel generator testbench
// Drives load and step items into the line engine in random bursts, pops
// pixels with a stall pattern of its own, steps the frame base through
// several values between phases and reports the checker's verdict.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blpg_pkg::*;

  localparam int ROW_SHIFT      = 10;
  localparam int X_BITS         = 9;
  localparam int Y_BITS         = 8;
  localparam int X_MAX          = (1 << X_BITS) - 1;
  localparam int Y_MAX          = (1 << Y_BITS) - 1;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 225;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  push       = 1'b0;
  logic                  func       = FUNC_LOAD;
  logic [X_BITS-1:0]     x_start    = '0;
  logic [Y_BITS-1:0]     y_start    = '0;
  logic [X_BITS-1:0]     x_end      = '0;
  logic [Y_BITS-1:0]     y_end      = '0;
  logic [COLOR_BITS-1:0] line_color = '0;
  logic                  pop        = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [ADDR_BITS-1:0]  cfg_data   = '0;
  logic                  full;
  logic                  empty;
  logic                  cfg_ready;
  logic [X_BITS-1:0]     pixel_x;
  logic [Y_BITS-1:0]     pixel_y;
  logic [ADDR_BITS-1:0]  pixel_address;
  logic [COLOR_BITS-1:0] pixel_rgb;
  logic                  last_pixel;

  int errors;
  int pending;
  int items_sent  = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  int rx_cycle    = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  bresenham_line_pixel_generator_core #(
    .ROW_SHIFT(ROW_SHIFT),
    .X_BITS   (X_BITS),
    .Y_BITS   (Y_BITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .func         (func),
    .x_start      (x_start),
    .y_start      (y_start),
    .x_end        (x_end),
    .y_end        (y_end),
    .line_color   (line_color),
    .empty        (empty),
    .pop          (pop),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_address(pixel_address),
    .pixel_rgb    (pixel_rgb),
    .last_pixel   (last_pixel),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  bresenham_line_pixel_generator_checker #(
    .ROW_SHIFT(ROW_SHIFT),
    .X_BITS   (X_BITS),
    .Y_BITS   (Y_BITS)
  ) pixel_checker (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .func         (func),
    .x_start      (x_start),
    .y_start      (y_start),
    .x_end        (x_end),
    .y_end        (y_end),
    .line_color   (line_color),
    .empty        (empty),
    .pop          (pop),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_address(pixel_address),
    .pixel_rgb    (pixel_rgb),
    .last_pixel   (last_pixel),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending)
  );

  // Pixel sink: cycle through free-running, light, heavy and periodic stalls.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      case (rx_cycle[9:8])
        2'd0:    pop <= 1'b1;
        2'd1:    pop <= $urandom_range(0, 3) != 0;
        2'd2:    pop <= $urandom_range(0, 3) == 0;
        default: pop <= rx_cycle[3:0] < 4'd11;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clip(int v, int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // Present one item and hold it until the transfer; open a gap between bursts.
  task push_item(input logic f, input int xs, input int ys, input int xe, input int ye,
                 input int rgb);
    if (gaps_on && burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    push       <= 1'b1;
    func       <= f;
    x_start    <= X_BITS'(xs);
    y_start    <= Y_BITS'(ys);
    x_end      <= X_BITS'(xe);
    y_end      <= Y_BITS'(ye);
    line_color <= COLOR_BITS'(rgb);
    do @(posedge clk); while (full);
  endtask

  task step_pixel;
    push_item(FUNC_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Drain every pixel, then let a queued load work through the block.
  task wait_idle;
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_frame_base(input logic [ADDR_BITS-1:0] base);
    cfg_valid <= 1'b1;
    cfg_data  <= base;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly short lines drawn to the end; some long, some cut off by the
  // next load, some followed by steps with no line active.
  task draw_random_line;
    int xs;
    int ys;
    int xe;
    int ye;
    int adx;
    int ady;
    int len;
    int steps;
    int extra;
    xs = $urandom_range(0, X_MAX);
    ys = $urandom_range(0, Y_MAX);
    if ($urandom_range(0, 15) == 0) begin
      xe = $urandom_range(0, X_MAX);
      ye = $urandom_range(0, Y_MAX);
    end else begin
      xe = clip(xs + int'($urandom_range(0, 24)) - 12, X_MAX);
      ye = clip(ys + int'($urandom_range(0, 24)) - 12, Y_MAX);
    end
    adx   = (xe > xs) ? xe - xs : xs - xe;
    ady   = (ye > ys) ? ye - ys : ys - ye;
    len   = ((adx > ady) ? adx : ady) + 1;
    steps = len;
    extra = 0;
    case ($urandom_range(0, 9))
      0:       steps = $urandom_range(0, len - 1);
      1:       extra = $urandom_range(1, 3);
      default: ;
    endcase
    push_item(FUNC_LOAD, xs, ys, xe, ye, $urandom);
    repeat (steps + extra) step_pixel();
    items_sent += 1 + steps;
  endtask

  initial begin
    logic [ADDR_BITS-1:0] bases [6];
    int goal;
    bases = '{32'hFFFF_FFFF, 32'hFFFC_0000, $urandom, 32'h7FFF_FC00, $urandom, 32'h0000_0000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_frame_base(32'h0000_0000);

    // directed: idle step, single point, abandoned line, lines in several directions
    step_pixel();
    push_item(FUNC_LOAD, 0, 0, 0, 0, 32'h0000);
    step_pixel();
    step_pixel();
    push_item(FUNC_LOAD, X_MAX, Y_MAX, 0, 0, 32'hFFFF);
    repeat (3) step_pixel();
    push_item(FUNC_LOAD, 5, 250, 8, Y_MAX, 32'hA5A5);
    repeat (6) step_pixel();
    push_item(FUNC_LOAD, 2, Y_MAX, 0, Y_MAX, 32'h5A5A);
    repeat (3) step_pixel();
    push_item(FUNC_LOAD, 7, 3, 7, 0, 32'h1234);
    repeat (4) step_pixel();
    items_sent += 24;

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_frame_base(bases[p]);
      gaps_on = (p % 3) != 2;
      goal    = items_sent + PHASE_ITEMS;
      while (items_sent < goal) draw_random_line();
    end

    wait_idle();
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
